// ===== hdl/bpe_pkg.sv =====
// Shared types and constants for the bracket path extractor.
// Used by the interfaces, the configuration registers, the core and the top level.
package bpe_pkg;

  localparam int CHAR_BITS      = 8;
  localparam int STEP_BITS      = 4;
  localparam int ENTRY_BITS     = 8;
  localparam int ENTRY_COUNT    = 8;
  localparam int CFG_DATA_BITS  = ENTRY_BITS * ENTRY_COUNT;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [ENTRY_BITS-1:0] SIBLING_MAX       = '1;
  localparam logic [CHAR_BITS-1:0]  OPEN_CHAR_RESET   = 8'd123;
  localparam logic [CHAR_BITS-1:0]  CLOSE_CHAR_RESET  = 8'd125;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_OPEN_CHAR     = 3'd0,
    REG_CLOSE_CHAR    = 3'd1,
    REG_INCLUDE_OPEN  = 3'd2,
    REG_INCLUDE_CLOSE = 3'd3,
    REG_PATH_LENGTH   = 3'd4,
    REG_PATH_ENTRIES  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0]     open_char;
    logic [CHAR_BITS-1:0]     close_char;
    logic                     include_open;
    logic                     include_close;
    logic [STEP_BITS-1:0]     path_length;
    logic [CFG_DATA_BITS-1:0] path_entries;
  } cfg_t;

endpackage

// ===== hdl/bpe_stream_if.sv =====
// Valid/ready channel interfaces: text bytes in, span results out.
// Depends on bpe_pkg for the byte width.
interface bpe_char_if;
  logic                      valid;
  logic                      ready;
  logic [bpe_pkg::CHAR_BITS-1:0] char_code;
  logic                      last_char;

  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface bpe_span_if #(
  parameter int INDEX_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [INDEX_BITS-1:0] start_index;
  logic [INDEX_BITS-1:0] span_length;

  modport source (output valid, found, start_index, span_length, input ready);
  modport sink   (input valid, found, start_index, span_length, output ready);
endinterface

// ===== hdl/bpe_cfg_regs.sv =====
// Configuration registers of the bracket path extractor.
// Depends on bpe_pkg for the register index codes and the cfg_t bundle.
module bpe_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bpe_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [bpe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output bpe_pkg::cfg_t                       cfg
);
  import bpe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_char     <= OPEN_CHAR_RESET;
      cfg.close_char    <= CLOSE_CHAR_RESET;
      cfg.include_open  <= 1'b1;
      cfg.include_close <= 1'b1;
      cfg.path_length   <= '0;
      cfg.path_entries  <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_OPEN_CHAR:     cfg.open_char     <= cfg_data[CHAR_BITS-1:0];
        REG_CLOSE_CHAR:    cfg.close_char    <= cfg_data[CHAR_BITS-1:0];
        REG_INCLUDE_OPEN:  cfg.include_open  <= cfg_data[0];
        REG_INCLUDE_CLOSE: cfg.include_close <= cfg_data[0];
        REG_PATH_LENGTH:   cfg.path_length   <= cfg_data[STEP_BITS-1:0];
        REG_PATH_ENTRIES:  cfg.path_entries  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/bpe_path_core.sv =====
// Input word register, path tracking state and per-byte step logic.
// Depends on bpe_pkg; feeds its result into bpe_out_reg.
module bpe_path_core #(
  parameter int MAX_PATH   = 8,
  parameter int INDEX_BITS = 16,
  parameter int DEPTH_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bpe_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [bpe_pkg::CHAR_BITS-1:0] in_char,
  input  logic                  in_last,
  input  logic                  out_free,
  output logic                  res_load,
  output logic                  res_found,
  output logic [INDEX_BITS-1:0] res_start,
  output logic [INDEX_BITS-1:0] res_length
);
  import bpe_pkg::*;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  // input word register
  logic                 s1_valid;
  logic [CHAR_BITS-1:0] s1_char;
  logic                 s1_last;

  // per-text state
  logic [DEPTH_BITS-1:0] depth_count, depth_count_next;
  logic [ENTRY_BITS-1:0] sibling_count, sibling_count_next;
  logic [STEP_BITS-1:0]  path_step, path_step_next;
  logic                  capturing, capturing_next;
  logic [INDEX_BITS-1:0] capture_start, capture_start_next;
  logic [INDEX_BITS-1:0] byte_position, byte_position_next;
  logic                  reported, reported_next;

  logic [STEP_BITS-1:0]  plen;
  logic [STEP_BITS-1:0]  step_inc;
  logic [ENTRY_BITS-1:0] want;
  logic                  active, is_open, is_close;
  logic                  step_try, advance, hit, emit_found, produce, s1_advance;
  logic [INDEX_BITS:0]   span_s, span_e, span_len;

  always_comb begin
    plen = (cfg.path_length > STEP_BITS'(MAX_PATH)) ? STEP_BITS'(MAX_PATH)
                                                     : cfg.path_length;
    active   = !reported && (cfg.open_char != cfg.close_char);
    is_open  = active && (s1_char == cfg.open_char);
    is_close = active && (s1_char == cfg.close_char);
    want     = cfg.path_entries[path_step[2:0]*ENTRY_BITS +: ENTRY_BITS];
    step_inc = path_step + 1'b1;
    step_try = is_open && !capturing && (plen != '0) &&
               (depth_count == DEPTH_BITS'(path_step)) && (path_step < plen);
    advance  = step_try && (sibling_count >= want);
    hit      = advance && (step_inc >= plen);
    emit_found = is_close && capturing && (depth_count == DEPTH_BITS'(plen));

    // span bounds one bit wider, then clamp
    span_s   = {1'b0, capture_start} + (INDEX_BITS+1)'(!cfg.include_open);
    span_e   = {1'b0, byte_position} + (INDEX_BITS+1)'(cfg.include_close);
    span_len = (span_e > span_s) ? (span_e - span_s) : '0;

    produce    = emit_found || (s1_last && !reported);
    s1_advance = s1_valid && (out_free || !produce);
    in_ready   = !s1_valid || s1_advance;

    res_load   = s1_advance && produce;
    res_found  = emit_found;
    res_start  = !emit_found ? '0 :
                 (span_s[INDEX_BITS] ? INDEX_MAX : span_s[INDEX_BITS-1:0]);
    res_length = !emit_found ? '0 :
                 (span_len[INDEX_BITS] ? INDEX_MAX : span_len[INDEX_BITS-1:0]);
  end

  always_comb begin
    depth_count_next   = depth_count;
    sibling_count_next = sibling_count;
    path_step_next     = path_step;
    capturing_next     = capturing;
    capture_start_next = capture_start;
    reported_next      = reported;
    byte_position_next = (byte_position != INDEX_MAX) ? byte_position + 1'b1
                                                      : byte_position;
    if (is_open && depth_count != DEPTH_MAX) begin
      depth_count_next = depth_count + 1'b1;
    end else if (is_close && depth_count != '0) begin
      depth_count_next = depth_count - 1'b1;
    end
    if (advance) begin
      sibling_count_next = '0;
      path_step_next     = step_inc;
    end else if (step_try && sibling_count != SIBLING_MAX) begin
      sibling_count_next = sibling_count + 1'b1;
    end
    if (hit) begin
      capturing_next     = 1'b1;
      capture_start_next = byte_position;
    end
    if (emit_found) begin
      capturing_next = 1'b0;
      reported_next  = 1'b1;
    end
    // end of text: start over
    if (s1_last) begin
      depth_count_next   = '0;
      sibling_count_next = '0;
      path_step_next     = '0;
      capturing_next     = 1'b0;
      capture_start_next = '0;
      byte_position_next = '0;
      reported_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_char <= in_char;
      s1_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_count   <= '0;
      sibling_count <= '0;
      path_step     <= '0;
      capturing     <= 1'b0;
      capture_start <= '0;
      byte_position <= '0;
      reported      <= 1'b0;
    end else if (s1_advance) begin
      depth_count   <= depth_count_next;
      sibling_count <= sibling_count_next;
      path_step     <= path_step_next;
      capturing     <= capturing_next;
      capture_start <= capture_start_next;
      byte_position <= byte_position_next;
      reported      <= reported_next;
    end
  end

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(capturing && reported))
    else $error("capturing while span already reported");

  a_text_clear: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_last |=> depth_count == '0 && !reported && !capturing &&
                              byte_position == '0 && path_step == '0)
    else $error("state not cleared after last byte");

  a_pos_count: assert property (@(posedge clk) disable iff (rst)
    s1_advance && !s1_last && byte_position != INDEX_MAX
      |=> byte_position == $past(byte_position) + 1'b1)
    else $error("byte position did not advance");

endmodule

// ===== hdl/bpe_out_reg.sv =====
// Result register on the output channel; holds a word while the receiver stalls.
// Depends on bpe_pkg only through the core that loads it.
module bpe_out_reg #(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  load_found,
  input  logic [INDEX_BITS-1:0] load_start,
  input  logic [INDEX_BITS-1:0] load_length,
  output logic                  free,
  output logic                  valid,
  input  logic                  ready,
  output logic                  found,
  output logic [INDEX_BITS-1:0] start_index,
  output logic [INDEX_BITS-1:0] span_length
);

  assign free = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      found       <= load_found;
      start_index <= load_start;
      span_length <= load_length;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result word overwritten while stalled");

  a_empty_miss: assert property (@(posedge clk) disable iff (rst)
    valid && !found |-> start_index == '0 && span_length == '0)
    else $error("not-found word carries a span");

endmodule

// ===== hdl/bracket_path_extractor.sv =====
// Bracket path extractor: follows a path of sibling indices through nested
// brackets in a byte stream and reports the span it leads to.
// Depends on bpe_pkg, bpe_stream_if, bpe_cfg_regs, bpe_path_core, bpe_out_reg.
//
// Usage:
//   char_in carries one text byte per word plus a last-byte mark. span_out
//   carries at most one word per byte: found with start and length at the
//   matching close bracket, or not found at the last byte of a text that
//   gave no span. The cfg port writes open_char, close_char, include_open,
//   include_close, path_length and path_entries (indexes 0 to 5); write it
//   only while no text is in flight.
//   A result reaches span_out through the input word and result registers.
//   Throughput: one byte per cycle unless stalled; all per-byte work is a
//   few counter compares between the input word and the result registers.
//   A stalled receiver holds the result register; the input register keeps
//   taking bytes that give no result and holds the first byte that does.
//   Reset restores the default brackets, an empty path, and clears all state.
module bracket_path_extractor #(
  parameter int MAX_PATH   = 8,
  parameter int INDEX_BITS = 16,
  parameter int DEPTH_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  bpe_char_if.sink                           char_in,
  bpe_span_if.source                         span_out,
  input  logic                               cfg_write,
  input  logic [bpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bpe_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import bpe_pkg::*;

  cfg_t                  cfg;
  logic                  out_free;
  logic                  res_load;
  logic                  res_found;
  logic [INDEX_BITS-1:0] res_start;
  logic [INDEX_BITS-1:0] res_length;

  bpe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpe_path_core #(
    .MAX_PATH   (MAX_PATH),
    .INDEX_BITS (INDEX_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (char_in.valid),
    .in_ready   (char_in.ready),
    .in_char    (char_in.char_code),
    .in_last    (char_in.last_char),
    .out_free   (out_free),
    .res_load   (res_load),
    .res_found  (res_found),
    .res_start  (res_start),
    .res_length (res_length)
  );

  bpe_out_reg #(
    .INDEX_BITS (INDEX_BITS)
  ) u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (res_load),
    .load_found  (res_found),
    .load_start  (res_start),
    .load_length (res_length),
    .free        (out_free),
    .valid       (span_out.valid),
    .ready       (span_out.ready),
    .found       (span_out.found),
    .start_index (span_out.start_index),
    .span_length (span_out.span_length)
  );

endmodule

// ===== dv/tb_bracket_path_extractor.sv =====
// Testbench for bracket_path_extractor: drives text bytes with random idling and
// checks every span word against an in-bench path tracker.
// Depends on bpe_pkg, bpe_stream_if and the bracket_path_extractor top level.
module tb_bracket_path_extractor;
  import bpe_pkg::*;

  localparam int MAX_PATH   = 8;
  localparam int INDEX_BITS = 16;
  localparam int DEPTH_BITS = 8;

  localparam logic [DEPTH_BITS-1:0]     DEPTH_TOP      = '1;
  localparam logic [INDEX_BITS-1:0]     INDEX_TOP      = '1;
  localparam logic [CFG_INDEX_BITS-1:0] UNMAPPED_INDEX = 3'd6;
  localparam int                        DRAIN_CYCLES   = 4;
  localparam int                        HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 is_last;
  } char_word_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] start_index;
    logic [INDEX_BITS-1:0] span_length;
  } span_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  bpe_char_if                            char_bus ();
  bpe_span_if #(.INDEX_BITS(INDEX_BITS)) span_bus ();

  bracket_path_extractor #(
    .MAX_PATH  (MAX_PATH),
    .INDEX_BITS(INDEX_BITS),
    .DEPTH_BITS(DEPTH_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_bus),
    .span_out (span_bus),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadow and per-text tracking state
  cfg_t                  regs;
  logic [DEPTH_BITS-1:0] nest_depth;
  logic [ENTRY_BITS-1:0] sibling_seen;
  logic [STEP_BITS-1:0]  path_pos;
  logic                  in_capture;
  logic [INDEX_BITS-1:0] capture_at;
  logic [INDEX_BITS-1:0] text_pos;
  logic                  span_done;

  char_word_t char_queue[$];
  span_word_t span_expected[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_start     = 1'b0;
  bit hold_off       = 1'b0;
  int mismatch_count = 0;

  function automatic void clear_text();
    nest_depth   = '0;
    sibling_seen = '0;
    path_pos     = '0;
    in_capture   = 1'b0;
    capture_at   = '0;
    text_pos     = '0;
    span_done    = 1'b0;
  endfunction

  function automatic void follow_byte(input logic [CHAR_BITS-1:0] code,
                                      input logic is_last);
    logic [STEP_BITS-1:0]  plen;
    logic [ENTRY_BITS-1:0] want;
    logic [INDEX_BITS:0]   span_first;
    logic [INDEX_BITS:0]   span_end;
    logic [INDEX_BITS:0]   span_len;
    span_word_t            res;
    plen = (regs.path_length > MAX_PATH) ? STEP_BITS'(MAX_PATH) : regs.path_length;
    if (!span_done && regs.open_char != regs.close_char) begin
      if (code == regs.open_char) begin
        if (!in_capture && plen != 0 && nest_depth == path_pos && path_pos < plen) begin
          want = regs.path_entries[path_pos[2:0]*ENTRY_BITS +: ENTRY_BITS];
          if (sibling_seen >= want) begin
            path_pos     = path_pos + 1'b1;
            sibling_seen = '0;
            if (path_pos >= plen) begin
              in_capture = 1'b1;
              capture_at = text_pos;
            end
          end else if (sibling_seen != SIBLING_MAX) begin
            sibling_seen = sibling_seen + 1'b1;
          end
        end
        if (nest_depth != DEPTH_TOP) nest_depth = nest_depth + 1'b1;
      end else if (code == regs.close_char) begin
        if (in_capture && nest_depth == plen) begin
          span_first = {1'b0, capture_at} + (INDEX_BITS+1)'(!regs.include_open);
          span_end   = {1'b0, text_pos} + (INDEX_BITS+1)'(regs.include_close);
          span_len   = (span_end > span_first) ? span_end - span_first : '0;
          res.found       = 1'b1;
          res.start_index = (span_first > INDEX_TOP) ? INDEX_TOP
                                                     : span_first[INDEX_BITS-1:0];
          res.span_length = (span_len > INDEX_TOP) ? INDEX_TOP
                                                   : span_len[INDEX_BITS-1:0];
          span_expected.push_back(res);
          span_done  = 1'b1;
          in_capture = 1'b0;
        end
        if (nest_depth != 0) nest_depth = nest_depth - 1'b1;
      end
    end
    if (text_pos != INDEX_TOP) text_pos = text_pos + 1'b1;
    if (is_last) begin
      if (!span_done) span_expected.push_back('0);
      clear_text();
    end
  endfunction

  function automatic void add_word(input logic [CHAR_BITS-1:0] code, input logic is_last);
    char_queue.push_back('{code: code, is_last: is_last});
  endfunction

  function automatic logic [CHAR_BITS-1:0] filler_byte();
    logic [CHAR_BITS-1:0] b;
    do b = CHAR_BITS'($urandom); while (b == regs.open_char || b == regs.close_char);
    return b;
  endfunction

  // Mostly well-formed nesting that heads for the path depth; some texts are noise
  function automatic int add_text();
    logic [CHAR_BITS-1:0] text[$];
    int goal;
    int len;
    int depth;
    int r;
    bit noisy;
    goal  = ((regs.path_length > MAX_PATH) ? MAX_PATH : int'(regs.path_length)) + 1;
    len   = $urandom_range(20, 3) + 2 * goal;
    noisy = $urandom_range(99) < 20;
    depth = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (noisy) begin
        if (r < 30) text.push_back(regs.open_char);
        else if (r < 60) text.push_back(regs.close_char);
        else text.push_back(CHAR_BITS'($urandom));
      end else if (r < ((depth < goal) ? 50 : 25)) begin
        text.push_back(regs.open_char);
        depth++;
      end else if (r < 75 && depth > 0) begin
        text.push_back(regs.close_char);
        depth--;
      end else begin
        text.push_back(filler_byte());
      end
    end
    if (!noisy) begin
      while (depth > 0) begin
        text.push_back(regs.close_char);
        depth--;
      end
    end
    foreach (text[i]) add_word(text[i], i == text.size() - 1);
    return text.size();
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_OPEN_CHAR:     regs.open_char     = value[CHAR_BITS-1:0];
      REG_CLOSE_CHAR:    regs.close_char    = value[CHAR_BITS-1:0];
      REG_INCLUDE_OPEN:  regs.include_open  = value[0];
      REG_INCLUDE_CLOSE: regs.include_close = value[0];
      REG_PATH_LENGTH:   regs.path_length   = value[STEP_BITS-1:0];
      REG_PATH_ENTRIES:  regs.path_entries  = value;
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Upper data bits carry junk so narrow registers must mask them
  task automatic load_setup(input logic [CHAR_BITS-1:0] open_c,
                            input logic [CHAR_BITS-1:0] close_c,
                            input logic inc_open, input logic inc_close,
                            input logic [STEP_BITS-1:0] plen,
                            input logic [CFG_DATA_BITS-1:0] entries);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_OPEN_CHAR, {junk[CFG_DATA_BITS-1:CHAR_BITS], open_c});
    write_reg(REG_CLOSE_CHAR, {junk[CFG_DATA_BITS-1:CHAR_BITS], close_c});
    write_reg(REG_INCLUDE_OPEN, {junk[CFG_DATA_BITS-1:1], inc_open});
    write_reg(REG_INCLUDE_CLOSE, {junk[CFG_DATA_BITS-1:1], inc_close});
    write_reg(REG_PATH_LENGTH, {junk[CFG_DATA_BITS-1:STEP_BITS], plen});
    write_reg(REG_PATH_ENTRIES, entries);
    finish_writes();
  endtask

  task automatic random_setup(input int forced_len);
    logic [CHAR_BITS-1:0]     open_c;
    logic [CHAR_BITS-1:0]     close_c;
    logic [STEP_BITS-1:0]     plen;
    logic [CFG_DATA_BITS-1:0] entries;
    int r;
    open_c  = CHAR_BITS'($urandom);
    close_c = ($urandom_range(99) < 10) ? open_c : CHAR_BITS'($urandom);
    r = $urandom_range(99);
    if (r < 5) plen = 0;
    else if (r < 80) plen = STEP_BITS'($urandom_range(4, 1));
    else if (r < 92) plen = STEP_BITS'($urandom_range(8, 5));
    else plen = STEP_BITS'($urandom_range(15, 9));
    for (int k = 0; k < ENTRY_COUNT; k++) begin
      entries[k*ENTRY_BITS +: ENTRY_BITS] =
        ($urandom_range(99) < 5) ? ENTRY_BITS'($urandom) : ENTRY_BITS'($urandom_range(2));
    end
    if (forced_len >= 0) begin
      plen = STEP_BITS'(forced_len);
      // swap the brackets to the byte extremes with all-ones sibling indexes
      if (forced_len == 0) begin
        open_c  = '1;
        close_c = '0;
        entries = '1;
      end
    end
    load_setup(open_c, close_c, 1'($urandom_range(1)), 1'($urandom_range(1)), plen,
               entries);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (char_queue.size() != 0 || char_bus.valid || span_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Byte driver: hold a word until taken, then offer the next or idle
  always @(posedge clk) begin : drive_chars
    char_word_t w;
    if (rst) begin
      char_bus.valid <= 1'b0;
    end else begin
      if (char_bus.valid && char_bus.ready) follow_byte(char_bus.char_code, char_bus.last_char);
      if (!char_bus.valid || char_bus.ready) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = char_queue.pop_front();
          char_bus.valid     <= 1'b1;
          char_bus.char_code <= w.code;
          char_bus.last_char <= w.is_last;
        end else begin
          char_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Span monitor: compare each taken word against the oldest prediction
  always @(posedge clk) begin : check_spans
    span_word_t got;
    span_word_t want;
    if (rst) begin
      span_bus.ready <= 1'b0;
    end else begin
      if (span_bus.valid && span_bus.ready) begin
        got = '{found: span_bus.found, start_index: span_bus.start_index,
                span_length: span_bus.span_length};
        if (span_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected span word: found=%0d start=%0d length=%0d",
                     got.found, got.start_index, got.span_length);
        end else begin
          want = span_expected.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("span mismatch: expected found=%0d start=%0d length=%0d,",
                       want.found, want.start_index, want.span_length,
                       " got found=%0d start=%0d length=%0d",
                       got.found, got.start_index, got.span_length);
          end
        end
      end
      span_bus.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_start);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb_bracket_path_extractor: errors");
    $finish;
  end

  initial begin
    int send_idle_by_phase[4];
    int recv_stall_by_phase[4];
    int forced_len_by_phase[4];
    int pushed;
    send_idle_by_phase  = '{0, 74, 0, 26};
    recv_stall_by_phase = '{0, 0, 74, 26};
    forced_len_by_phase = '{-1, 8, 15, 0};
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    char_bus.last_char = 1'b0;
    span_bus.ready     = 1'b0;
    cfg_write          = 1'b0;
    cfg_index          = REG_OPEN_CHAR;
    cfg_data           = '0;
    regs = '{open_char: OPEN_CHAR_RESET, close_char: CLOSE_CHAR_RESET, include_open: 1'b1,
             include_close: 1'b1, path_length: '0, path_entries: '0};
    clear_text();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset setup has an empty path: not found
    add_word(8'd123, 1'b0);
    add_word(8'd125, 1'b1);
    drain();

    // One step: span found, then silence for the rest of the text;
    // then a match on the last byte gives only the found word
    load_setup(8'd123, 8'd125, 1'b1, 1'b1, 4'd1, '0);
    add_word(8'd123, 1'b0);
    add_word(8'h78, 1'b0);
    add_word(8'd125, 1'b0);
    add_word(8'h7A, 1'b1);
    add_word(8'd123, 1'b0);
    add_word(8'd125, 1'b1);
    drain();

    // Both brackets excluded from an empty pair: zero length, never negative
    load_setup(8'd123, 8'd125, 1'b0, 1'b0, 4'd1, '0);
    add_word(8'd123, 1'b0);
    add_word(8'd125, 1'b1);
    drain();

    // Same byte for open and close: nothing counts as a bracket
    load_setup(8'h22, 8'h22, 1'b1, 1'b1, 4'd1, '0);
    add_word(8'h22, 1'b0);
    add_word(8'h22, 1'b1);
    drain();

    // Second child at depth one, siblings counted since the last step
    load_setup(8'd123, 8'd125, 1'b1, 1'b1, 4'd2, 64'h0100);
    add_word(8'd123, 1'b0);
    add_word(8'd123, 1'b0);
    add_word(8'd125, 1'b0);
    add_word(8'd123, 1'b0);
    add_word(8'd125, 1'b0);
    add_word(8'd125, 1'b1);
    drain();

    // Byte extremes as brackets; a write to an unmapped index must change nothing
    load_setup(8'h00, 8'hFF, 1'b1, 1'b1, 4'd1, '0);
    write_reg(UNMAPPED_INDEX, {$urandom, $urandom});
    finish_writes();
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        random_setup((blk == 0) ? forced_len_by_phase[ph] : -1);
        if (ph == 0 && blk == 0) hold_start = 1'b1;
        pushed = 0;
        while (pushed < ((ph == 0 && blk == 0) ? 80 : 24)) pushed += add_text();
      end
      if (ph == 0) begin
        // Nest past the depth limit, then close below zero
        drain();
        load_setup(8'h28, 8'h29, 1'b1, 1'b1, 4'd1, '0);
        repeat (258) add_word(8'h28, 1'b0);
        repeat (261) add_word(8'h29, 1'b0);
        add_word(filler_byte(), 1'b1);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_bracket_path_extractor: clean");
    end else begin
      $display("tb_bracket_path_extractor: errors");
    end
    $finish;
  end

endmodule
